[rtl/wvsa_pkg.sv]
`default_nettype none
package wvsa_pkg;

    localparam int unsigned NUM_REGS = 6;
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic [2:0] REG_R0_C01 = 3'd0;
    localparam logic [2:0] REG_R0_C23 = 3'd1;
    localparam logic [2:0] REG_R1_C01 = 3'd2;
    localparam logic [2:0] REG_R1_C23 = 3'd3;
    localparam logic [2:0] REG_R2_C01 = 3'd4;
    localparam logic [2:0] REG_R2_C23 = 3'd5;

    typedef struct packed {
        logic               command;
        logic [9:0]         vertex_index;
        logic signed [31:0] in_pos_x;
        logic signed [31:0] in_pos_y;
        logic signed [31:0] in_pos_z;
        logic [16:0]        bone_weight;
        logic signed [31:0] in_norm_x;
        logic signed [31:0] in_norm_y;
        logic signed [31:0] in_norm_z;
        logic               batch_end;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         out_index;
        logic signed [31:0] acc_pos_x;
        logic signed [31:0] acc_pos_y;
        logic signed [31:0] acc_pos_z;
        logic signed [31:0] acc_norm_x;
        logic signed [31:0] acc_norm_y;
        logic signed [31:0] acc_norm_z;
        logic               saturated;
        logic               batch_done;
    } t_out_item;

    // classified job handed from the front to the back
    typedef struct packed {
        logic               clear;
        logic               in_range;
        logic [9:0]         index;
        logic [16:0]        weight;
        logic [191:0]       vec;
        logic               batch_end;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic flag);
        flag = 1'b0;
        if (v > 66'sh0_7FFF_FFFF) begin
            flag = 1'b1;
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            flag = 1'b1;
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

[rtl/weighted_vertex_skin_accumulate_top.sv]
`default_nettype none
// Linear blend skinning accumulator: each transaction transforms a position
// by the 3x4 bone matrix and a normal by its 3x3 part, scales both by the
// weight and saturating-adds them into the vertex store, returning the entry;
// a clear zeroes and returns the entry, an out-of-range index returns zeros.
// After reset a clearing pass zeroes the store before any queued transaction
// is processed. A new transaction is taken only once the last result is
// registered, which waits until the previous result is popped. A multiplier
// bank walks the six components in turn for the transform, then a weight multiplier walks them again.
module weighted_vertex_skin_accumulate_top #(
    parameter int unsigned VERTEX_COUNT = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire wvsa_pkg::t_in_item i_item,
    output logic                 empty,
    input  wire                  pop,
    output wvsa_pkg::t_out_item  o_result,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [63:0]          i_cfg_data
);
    logic [383:0]   r_regs;
    logic           job_valid;
    logic           job_take;
    wvsa_pkg::t_job job;
    logic           busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg_valid && 32'(i_cfg_index) < wvsa_pkg::NUM_REGS) begin
            r_regs[32'(i_cfg_index)*64 +: 64] <= i_cfg_data;
        end
    end

    wvsa_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    wvsa_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_regs(r_regs), .i_job_valid(job_valid),
        .o_job_take(job_take), .i_job(job), .o_busy(busy),
        .o_empty(empty), .i_pop(pop), .o_result
    );

    a_empty_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> busy) else $error("result without busy");
endmodule
`default_nettype wire

[rtl/wvsa_front.sv]
`default_nettype none
module wvsa_front #(
    parameter int unsigned VERTEX_COUNT = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  wire wvsa_pkg::t_in_item i_item,
    output logic                 o_job_valid,
    input  wire                  i_job_take,
    output wvsa_pkg::t_job       o_job
);
    localparam int unsigned DEPTH = 2;

    wvsa_pkg::t_job r_q [DEPTH];
    logic [1:0]     r_cnt;
    logic           r_wp;
    logic           r_rp;
    wvsa_pkg::t_job n_job;
    logic           push_ok;
    logic           pop_ok;

    always_comb begin
        n_job.clear     = (i_item.command == wvsa_pkg::CMD_CLEAR);
        n_job.in_range  = ({22'd0, i_item.vertex_index} < 32'(VERTEX_COUNT));
        n_job.index     = i_item.vertex_index;
        n_job.weight    = i_item.bone_weight[16] ? 17'h10000 : i_item.bone_weight;
        n_job.vec       = {i_item.in_pos_x, i_item.in_pos_y, i_item.in_pos_z,
                           i_item.in_norm_x, i_item.in_norm_y, i_item.in_norm_z};
        n_job.batch_end = i_item.batch_end;
    end

    assign o_full      = (r_cnt == 2'(DEPTH));
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end
endmodule
`default_nettype wire

[rtl/wvsa_back.sv]
`default_nettype none
module wvsa_back #(
    parameter int unsigned VERTEX_COUNT = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [383:0]         i_regs,
    input  wire                  i_job_valid,
    output logic                 o_job_take,
    input  wire wvsa_pkg::t_job  i_job,
    output logic                 o_busy,
    output logic                 o_empty,
    input  wire                  i_pop,
    output wvsa_pkg::t_out_item  o_result
);
    localparam int unsigned AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_WMUL  = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]  r_state;
    logic [AW:0] r_clr_addr;
    logic [2:0]  r_k;

    logic [191:0] mem [VERTEX_COUNT];
    logic [191:0] r_rd;
    logic         r_we;
    logic [AW-1:0] r_wa;
    logic [191:0] r_wd;

    wvsa_pkg::t_job r_job;
    logic [AW-1:0]      job_addr;
    logic signed [31:0] r_vin [6];
    logic signed [47:0] r_prod [3];
    logic signed [31:0] r_tr [6];
    logic signed [47:0] r_wp;
    logic signed [31:0] r_acc [6];
    logic               r_sat;
    logic               r_out_valid;
    wvsa_pkg::t_out_item r_out;

    logic [1:0] row;
    logic       is_norm;
    logic signed [31:0] c0, c1, c2, tt;
    logic signed [65:0] sum;
    logic signed [31:0] clamp_v;
    logic               clamp_f;
    logic signed [65:0] asum;
    logic signed [31:0] aclamp_v;
    logic               aclamp_f;
    logic signed [31:0] old_v;

    function automatic logic signed [31:0] rword(input logic [383:0] rg,
                                                 input int unsigned reg_i,
                                                 input logic hi);
        logic [63:0] r;
        r = rg[reg_i*64 +: 64];
        rword = hi ? r[63:32] : r[31:0];
    endfunction

    always_comb begin
        is_norm = (r_k >= 3'd3);
        row     = is_norm ? 2'(r_k - 3'd3) : r_k[1:0];
        c0 = rword(i_regs, 32'(row) * 2, 1'b0);
        c1 = rword(i_regs, 32'(row) * 2, 1'b1);
        c2 = rword(i_regs, 32'(row) * 2 + 1, 1'b0);
        tt = is_norm ? 32'sd0 : rword(i_regs, 32'(row) * 2 + 1, 1'b1);
        sum = 66'(r_prod[0]) + 66'(r_prod[1]) + 66'(r_prod[2]) + 66'(tt);
        clamp_v = wvsa_pkg::sat32(sum, clamp_f);
        old_v = r_rd[(5 - r_k) * 32 +: 32];
        asum = 66'(old_v) + 66'(r_wp);
        aclamp_v = wvsa_pkg::sat32(asum, aclamp_f);
    end

    assign job_addr   = AW'(r_job.index);
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign o_busy     = (r_state != S_IDLE) || r_out_valid;
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        r_rd <= mem[job_addr];
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_k         <= 3'd0;
        end else begin
            if (r_out_valid && i_pop) r_out_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_we <= 1'b1;
                    r_wa <= r_clr_addr[AW-1:0];
                    r_wd <= '0;
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == (AW+1)'(VERTEX_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_job_take) begin
                        r_job <= i_job;
                        for (int i = 0; i < 6; i++) r_vin[i] <= i_job.vec[(5-i)*32 +: 32];
                        r_sat <= 1'b0;
                        r_k   <= 3'd0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_MUL;
                S_MUL: begin
                    for (int i = 0; i < 3; i++) begin
                        r_prod[i] <= 48'(((i == 0 ? 64'(c0) : i == 1 ? 64'(c1) : 64'(c2))
                                     * 64'(r_vin[(is_norm ? 3 : 0) + i])) >>> 16);
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_tr[r_k] <= clamp_v;
                    r_sat <= r_sat | clamp_f;
                    if (r_k == 3'd5) begin
                        r_k <= 3'd0;
                        r_state <= S_WMUL;
                    end else begin
                        r_k <= r_k + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_WMUL: begin
                    r_wp <= 48'((64'(r_tr[r_k]) * $signed({47'd0, r_job.weight})) >>> 16);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_k] <= aclamp_v;
                    r_sat <= r_sat | aclamp_f;
                    if (r_k == 3'd5) r_state <= S_OUT;
                    else begin
                        r_k <= r_k + 3'd1;
                        r_state <= S_WMUL;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out.out_index  <= r_job.index;
                        r_out.batch_done <= r_job.batch_end;
                        if (!r_job.in_range) begin
                            r_out.saturated <= 1'b0;
                            {r_out.acc_pos_x, r_out.acc_pos_y, r_out.acc_pos_z,
                             r_out.acc_norm_x, r_out.acc_norm_y, r_out.acc_norm_z} <= '0;
                        end else if (r_job.clear) begin
                            r_out.saturated <= 1'b0;
                            {r_out.acc_pos_x, r_out.acc_pos_y, r_out.acc_pos_z,
                             r_out.acc_norm_x, r_out.acc_norm_y, r_out.acc_norm_z} <= '0;
                            r_we <= 1'b1;
                            r_wa <= job_addr;
                            r_wd <= '0;
                        end else begin
                            r_out.saturated <= r_sat;
                            r_out.acc_pos_x  <= r_acc[0];
                            r_out.acc_pos_y  <= r_acc[1];
                            r_out.acc_pos_z  <= r_acc[2];
                            r_out.acc_norm_x <= r_acc[3];
                            r_out.acc_norm_y <= r_acc[4];
                            r_out.acc_norm_z <= r_acc[5];
                            r_we <= 1'b1;
                            r_wa <= job_addr;
                            r_wd <= {r_acc[0], r_acc[1], r_acc[2],
                                     r_acc[3], r_acc[4], r_acc[5]};
                        end
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_state == S_READ) else $error("job take outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid) else $error("result dropped");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 3'd5) else $error("component counter overrun");
endmodule
`default_nettype wire
